[rtl/swd_pkg.sv]
// Shared types, fixed-point constants and EOS-80 coefficient table for the density pipeline.
package swd_pkg;

  typedef logic signed [63:0] q44_t;

  localparam int unsigned QF           = 44;
  localparam int unsigned IN_FRAC_DEF  = 10;
  localparam int unsigned OUT_FRAC_DEF = 16;
  localparam int unsigned NCOEF        = 41;
  localparam int unsigned FMAC_LAT     = 4;

  // Square root of salinity: operand holds S with 2*ROOT_FRAC fractional bits.
  localparam int unsigned ROOT_FRAC  = 20;
  localparam int unsigned SQ_XW      = 46;
  localparam int unsigned SQ_RW      = 24;
  localparam int unsigned SQ_STAGES  = 8;
  localparam int unsigned SQ_SPS     = 3;

  // Fractional quotient K / (K - p).
  localparam int unsigned DIV_QW     = 46;
  localparam int unsigned DIV_STAGES = 23;
  localparam int unsigned DIV_SPS    = 2;

  // Coefficients in Q44, rounded to nearest with ties away from zero.
  localparam q44_t COEF [NCOEF] = '{
    64'(((128'd999842594 << 45) / (128'd10 ** 6) + 128'd1) >> 1),
    64'(((128'd6793952 << 45) / (128'd10 ** 8) + 128'd1) >> 1),
    -(64'(((128'd9095290 << 45) / (128'd10 ** 9) + 128'd1) >> 1)),
    64'(((128'd1001685 << 45) / (128'd10 ** 10) + 128'd1) >> 1),
    -(64'(((128'd1120083 << 45) / (128'd10 ** 12) + 128'd1) >> 1)),
    64'(((128'd6536332 << 45) / (128'd10 ** 15) + 128'd1) >> 1),
    64'(((128'd824493 << 45) / (128'd10 ** 6) + 128'd1) >> 1),
    -(64'(((128'd40899 << 45) / (128'd10 ** 7) + 128'd1) >> 1)),
    64'(((128'd76438 << 45) / (128'd10 ** 9) + 128'd1) >> 1),
    -(64'(((128'd82467 << 45) / (128'd10 ** 11) + 128'd1) >> 1)),
    64'(((128'd53875 << 45) / (128'd10 ** 13) + 128'd1) >> 1),
    -(64'(((128'd572466 << 45) / (128'd10 ** 8) + 128'd1) >> 1)),
    64'(((128'd10227 << 45) / (128'd10 ** 8) + 128'd1) >> 1),
    -(64'(((128'd16546 << 45) / (128'd10 ** 10) + 128'd1) >> 1)),
    64'(((128'd48314 << 45) / (128'd10 ** 8) + 128'd1) >> 1),
    64'(((128'd1965221 << 45) / (128'd10 ** 2) + 128'd1) >> 1),
    64'(((128'd1484206 << 45) / (128'd10 ** 4) + 128'd1) >> 1),
    -(64'(((128'd2327105 << 45) / (128'd10 ** 6) + 128'd1) >> 1)),
    64'(((128'd1360477 << 45) / (128'd10 ** 8) + 128'd1) >> 1),
    -(64'(((128'd5155288 << 45) / (128'd10 ** 11) + 128'd1) >> 1)),
    64'(((128'd546746 << 45) / (128'd10 ** 4) + 128'd1) >> 1),
    -(64'(((128'd603459 << 45) / (128'd10 ** 6) + 128'd1) >> 1)),
    64'(((128'd109987 << 45) / (128'd10 ** 7) + 128'd1) >> 1),
    -(64'(((128'd61670 << 45) / (128'd10 ** 9) + 128'd1) >> 1)),
    64'(((128'd7944 << 45) / (128'd10 ** 5) + 128'd1) >> 1),
    64'(((128'd16483 << 45) / (128'd10 ** 6) + 128'd1) >> 1),
    -(64'(((128'd53009 << 45) / (128'd10 ** 8) + 128'd1) >> 1)),
    64'(((128'd3239908 << 45) / (128'd10 ** 6) + 128'd1) >> 1),
    64'(((128'd143713 << 45) / (128'd10 ** 8) + 128'd1) >> 1),
    64'(((128'd116092 << 45) / (128'd10 ** 9) + 128'd1) >> 1),
    -(64'(((128'd577905 << 45) / (128'd10 ** 12) + 128'd1) >> 1)),
    64'(((128'd22838 << 45) / (128'd10 ** 7) + 128'd1) >> 1),
    -(64'(((128'd10981 << 45) / (128'd10 ** 9) + 128'd1) >> 1)),
    -(64'(((128'd16078 << 45) / (128'd10 ** 10) + 128'd1) >> 1)),
    64'(((128'd191075 << 45) / (128'd10 ** 9) + 128'd1) >> 1),
    64'(((128'd850935 << 45) / (128'd10 ** 10) + 128'd1) >> 1),
    -(64'(((128'd612293 << 45) / (128'd10 ** 11) + 128'd1) >> 1)),
    64'(((128'd52787 << 45) / (128'd10 ** 12) + 128'd1) >> 1),
    -(64'(((128'd99348 << 45) / (128'd10 ** 11) + 128'd1) >> 1)),
    64'(((128'd20816 << 45) / (128'd10 ** 12) + 128'd1) >> 1),
    64'(((128'd91697 << 45) / (128'd10 ** 14) + 128'd1) >> 1)
  };

endpackage

[rtl/seawater_density_eos80.sv]
// Seawater density (UNESCO EOS-80) top level: a fully pipelined fixed-point datapath.
// The input channel takes temperature, salinity and pressure with in_valid_i and
// in_stall_o; a transaction completes on a rising edge with valid high and stall low.
// Each input saturates to its upper limit (40 C, 42 PSU, 1100 bar) before use.
// The output channel returns one density per input transaction on density_o with
// out_valid_o and out_stall_i, in the order the samples arrived.
// The longest chain is the temperature polynomials feeding the bulk modulus (seven
// multiply-add units), then the 23-stage fractional divider and one more multiply;
// every stage holds one sample, so a new sample can enter every cycle unless stalled.
// When the receiver stalls with a result pending, the whole pipeline freezes and
// in_stall_o is raised in the same cycle; nothing is dropped or repeated.
// Bubbles advance freely while the output register is empty.
// Reset clears all valid bits; the datapath registers are not reset.
module seawater_density_eos80 #(
  parameter int unsigned INPUT_FRAC_BITS  = swd_pkg::IN_FRAC_DEF,
  parameter int unsigned OUTPUT_FRAC_BITS = swd_pkg::OUT_FRAC_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [15:0] temperature_i,
  input  logic [15:0] salinity_i,
  input  logic [20:0] pressure_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [26:0] density_o
);

  localparam int unsigned PIPE_DEPTH = 57;
  localparam int unsigned QF         = swd_pkg::QF;
  localparam logic [31:0] T_TOP      = 32'd40 << INPUT_FRAC_BITS;
  localparam logic [31:0] S_TOP      = 32'd42 << INPUT_FRAC_BITS;
  localparam logic [31:0] P_TOP      = 32'd1100 << INPUT_FRAC_BITS;
  localparam logic [63:0] OUT_TOP    = 64'd1100 << OUTPUT_FRAC_BITS;
  localparam logic [63:0] OUT_RND    = 64'd1 << (QF - 1 - OUTPUT_FRAC_BITS);

  logic en;
  logic v_q [PIPE_DEPTH];
  logic out_vld_q;

  assign en          = !out_vld_q || !out_stall_i;
  assign in_stall_o  = !en;
  assign out_valid_o = out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PIPE_DEPTH; i++) begin
        v_q[i] <= 1'b0;
      end
      out_vld_q <= 1'b0;
    end else if (en) begin
      v_q[0] <= in_valid_i;
      for (int i = 1; i < PIPE_DEPTH; i++) begin
        v_q[i] <= v_q[i-1];
      end
      out_vld_q <= v_q[PIPE_DEPTH-1];
    end
  end

  // Input stage: saturate and convert to Q44.
  logic [31:0] t_sat, s_sat, p_sat;
  swd_pkg::q44_t t0_d, s0_d, p0_d, t0_q, s0_q, p0_q;
  logic [swd_pkg::SQ_XW-1:0] x0_d, x0_q;

  always_comb begin
    t_sat = (32'(temperature_i) > T_TOP) ? T_TOP : 32'(temperature_i);
    s_sat = (32'(salinity_i) > S_TOP) ? S_TOP : 32'(salinity_i);
    p_sat = (32'(pressure_i) > P_TOP) ? P_TOP : 32'(pressure_i);
    t0_d  = swd_pkg::q44_t'(64'(t_sat) << (QF - INPUT_FRAC_BITS));
    s0_d  = swd_pkg::q44_t'(64'(s_sat) << (QF - INPUT_FRAC_BITS));
    p0_d  = swd_pkg::q44_t'(64'(p_sat) << (QF - INPUT_FRAC_BITS));
    x0_d  = swd_pkg::SQ_XW'(64'(s_sat) << (2*swd_pkg::ROOT_FRAC - INPUT_FRAC_BITS));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t0_q <= t0_d;
      s0_q <= s0_d;
      p0_q <= p0_d;
      x0_q <= x0_d;
    end
  end

  // Temperature polynomials; the suffix is the cycle at which a value is ready.
  swd_pkg::q44_t a20, b16, c8, kw16, f12, g8, h12, i8, kp8, m8;

  swd_poly #(.START(0),  .NUM(6)) u_poly_a  (.clk_i, .en_i(en), .x_i(t0_q), .y_o(a20));
  swd_poly #(.START(6),  .NUM(5)) u_poly_b  (.clk_i, .en_i(en), .x_i(t0_q), .y_o(b16));
  swd_poly #(.START(11), .NUM(3)) u_poly_c  (.clk_i, .en_i(en), .x_i(t0_q), .y_o(c8));
  swd_poly #(.START(15), .NUM(5)) u_poly_kw (.clk_i, .en_i(en), .x_i(t0_q), .y_o(kw16));
  swd_poly #(.START(20), .NUM(4)) u_poly_f  (.clk_i, .en_i(en), .x_i(t0_q), .y_o(f12));
  swd_poly #(.START(24), .NUM(3)) u_poly_g  (.clk_i, .en_i(en), .x_i(t0_q), .y_o(g8));
  swd_poly #(.START(27), .NUM(4)) u_poly_h  (.clk_i, .en_i(en), .x_i(t0_q), .y_o(h12));
  swd_poly #(.START(31), .NUM(3)) u_poly_i  (.clk_i, .en_i(en), .x_i(t0_q), .y_o(i8));
  swd_poly #(.START(35), .NUM(3)) u_poly_kp (.clk_i, .en_i(en), .x_i(t0_q), .y_o(kp8));
  swd_poly #(.START(38), .NUM(3)) u_poly_m  (.clk_i, .en_i(en), .x_i(t0_q), .y_o(m8));

  // Operand alignment.
  swd_pkg::q44_t s8, s16, p20, p24, p28, c12, dt12, g12, f16, kw20, i16, b2_20, k0_24;
  swd_pkg::q44_t rho0_52;
  logic          bad56;

  // Salinity terms.
  logic [swd_pkg::SQ_RW-1:0] root8;
  swd_pkg::q44_t rootq8, ss4, dt8, s15_12;

  swd_sqrt u_sqrt (.clk_i, .en_i(en), .x_i(x0_q), .root_o(root8));
  assign rootq8 = swd_pkg::q44_t'(64'(root8) << (QF - swd_pkg::ROOT_FRAC));

  swd_dly #(.W(64), .N(8)) u_dly_s8  (.clk_i, .en_i(en), .d_i(s0_q), .q_o(s8));
  swd_dly #(.W(64), .N(8)) u_dly_s16 (.clk_i, .en_i(en), .d_i(s8),   .q_o(s16));
  swd_dly #(.W(64), .N(20)) u_dly_p20 (.clk_i, .en_i(en), .d_i(p0_q), .q_o(p20));
  swd_dly #(.W(64), .N(4))  u_dly_p24 (.clk_i, .en_i(en), .d_i(p20),  .q_o(p24));
  swd_dly #(.W(64), .N(4))  u_dly_p28 (.clk_i, .en_i(en), .d_i(p24),  .q_o(p28));

  swd_fmac u_ss  (.clk_i, .en_i(en), .a_i(s0_q), .b_i(s0_q), .c_i('0), .y_o(ss4));
  swd_fmac u_dt  (.clk_i, .en_i(en), .a_i(swd_pkg::COEF[14]), .b_i(ss4), .c_i('0),
                  .y_o(dt8));
  swd_fmac u_s15 (.clk_i, .en_i(en), .a_i(s8), .b_i(rootq8), .c_i('0), .y_o(s15_12));

  // One-atmosphere density.
  swd_pkg::q44_t x1_16, x2_20, rho0_21_d, rho0_21_q;

  swd_dly #(.W(64), .N(4)) u_dly_c12  (.clk_i, .en_i(en), .d_i(c8),  .q_o(c12));
  swd_dly #(.W(64), .N(4)) u_dly_dt12 (.clk_i, .en_i(en), .d_i(dt8), .q_o(dt12));
  swd_fmac u_x1 (.clk_i, .en_i(en), .a_i(c12), .b_i(s15_12), .c_i(dt12),  .y_o(x1_16));
  swd_fmac u_x2 (.clk_i, .en_i(en), .a_i(b16), .b_i(s16),    .c_i(x1_16), .y_o(x2_20));
  assign rho0_21_d = a20 + x2_20;

  // Bulk modulus at one atmosphere.
  swd_pkg::q44_t y2_16, y1_20, k0_21_d, k0_21_q;

  swd_dly #(.W(64), .N(4)) u_dly_g12  (.clk_i, .en_i(en), .d_i(g8),   .q_o(g12));
  swd_dly #(.W(64), .N(4)) u_dly_f16  (.clk_i, .en_i(en), .d_i(f12),  .q_o(f16));
  swd_dly #(.W(64), .N(4)) u_dly_kw20 (.clk_i, .en_i(en), .d_i(kw16), .q_o(kw20));
  swd_fmac u_y2 (.clk_i, .en_i(en), .a_i(g12), .b_i(s15_12), .c_i('0),    .y_o(y2_16));
  swd_fmac u_y1 (.clk_i, .en_i(en), .a_i(f16), .b_i(s16),    .c_i(y2_16), .y_o(y1_20));
  assign k0_21_d = kw20 + y1_20;

  // Pressure coefficients A and B.
  swd_pkg::q44_t z1_16, a1_20, b2_12;

  swd_dly #(.W(64), .N(8)) u_dly_i16 (.clk_i, .en_i(en), .d_i(i8), .q_o(i16));
  swd_fmac u_z1 (.clk_i, .en_i(en), .a_i(swd_pkg::COEF[34]), .b_i(s15_12), .c_i(h12),
                 .y_o(z1_16));
  swd_fmac u_a1 (.clk_i, .en_i(en), .a_i(i16), .b_i(s16), .c_i(z1_16), .y_o(a1_20));
  swd_fmac u_b2 (.clk_i, .en_i(en), .a_i(m8),  .b_i(s8),  .c_i(kp8),   .y_o(b2_12));

  // Secant bulk modulus K = k0 + (a1 + b2*p)*p.
  swd_pkg::q44_t w1_24, kk28;

  swd_dly #(.W(64), .N(8)) u_dly_b2 (.clk_i, .en_i(en), .d_i(b2_12),   .q_o(b2_20));
  swd_dly #(.W(64), .N(3)) u_dly_k0 (.clk_i, .en_i(en), .d_i(k0_21_q), .q_o(k0_24));
  swd_fmac u_w1 (.clk_i, .en_i(en), .a_i(b2_20), .b_i(p20), .c_i(a1_20), .y_o(w1_24));
  swd_fmac u_w2 (.clk_i, .en_i(en), .a_i(w1_24), .b_i(p24), .c_i(k0_24), .y_o(kk28));

  // Divisor K - p; a non-positive divisor forces the saturated result.
  swd_pkg::q44_t den_d, kk_q, den_q;
  logic          bad_d, bad_q;

  assign den_d = kk28 - p28;
  assign bad_d = den_d[63] || (den_d == '0);

  always_ff @(posedge clk_i) begin
    if (en) begin
      rho0_21_q <= rho0_21_d;
      k0_21_q   <= k0_21_d;
      kk_q      <= kk28;
      den_q     <= den_d;
      bad_q     <= bad_d;
    end
  end

  logic [swd_pkg::DIV_QW-1:0] q52;
  swd_pkg::q44_t              rho56;

  swd_div u_div (.clk_i, .en_i(en), .n_i(kk_q), .d_i(den_q), .q_o(q52));

  swd_dly #(.W(64), .N(31)) u_dly_rho0 (.clk_i, .en_i(en), .d_i(rho0_21_q), .q_o(rho0_52));
  swd_dly #(.W(1),  .N(27)) u_dly_bad  (.clk_i, .en_i(en), .d_i(bad_q),     .q_o(bad56));

  swd_fmac u_rho (.clk_i, .en_i(en), .a_i(rho0_52), .b_i(swd_pkg::q44_t'(64'(q52))),
                  .c_i('0), .y_o(rho56));

  // Output rounding and clamping.
  logic [63:0] res;
  logic [26:0] density_d, density_q;

  always_comb begin
    res = (64'(rho56) + OUT_RND) >> (QF - OUTPUT_FRAC_BITS);
    if (bad56) begin
      res = OUT_TOP;
    end else if (rho56[63]) begin
      res = '0;
    end else if (res > OUT_TOP) begin
      res = OUT_TOP;
    end
    density_d = res[26:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      density_q <= density_d;
    end
  end

  assign density_o = density_q;

endmodule

[rtl/swd_dly.sv]
// Enabled shift-register delay line used to align operands between pipeline branches.
module swd_dly #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int i = 1; i < N; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[N-1];

endmodule

[rtl/swd_fmac.sv]
// Four-stage Q44 multiply with round-to-nearest, saturation and a final add: y = c + a*b.
module swd_fmac (
  input  logic         clk_i,
  input  logic         en_i,
  input  swd_pkg::q44_t a_i,
  input  swd_pkg::q44_t b_i,
  input  swd_pkg::q44_t c_i,
  output swd_pkg::q44_t y_o
);

  logic [63:0]   ua_d, ub_d;
  logic [63:0]   ua_q, ub_q;
  logic          neg1_q, neg2_q, neg3_q;
  swd_pkg::q44_t c1_q, c2_q, c3_q;
  logic [63:0]   pp_q [4];
  logic [127:0]  sum;
  logic [83:0]   magf;
  logic [62:0]   mag_d, mag_q;
  logic [63:0]   y_d, y_q;

  assign ua_d = a_i[63] ? (~a_i + 64'd1) : a_i;
  assign ub_d = b_i[63] ? (~b_i + 64'd1) : b_i;

  // The rounding constant rides in the partial-product sum.
  always_comb begin
    sum = {64'b0, pp_q[0]} + {32'b0, pp_q[1], 32'b0} + {32'b0, pp_q[2], 32'b0}
        + {pp_q[3], 64'b0} + (128'd1 << (swd_pkg::QF - 1));
    magf  = sum[127:swd_pkg::QF];
    mag_d = (|magf[83:63]) ? '1 : magf[62:0];
  end

  // Conditional negate folded into the accumulate as invert plus carry-in.
  assign y_d = 64'(c3_q) + ({1'b0, mag_q} ^ {64{neg3_q}}) + {63'b0, neg3_q};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ua_q     <= ua_d;
      ub_q     <= ub_d;
      neg1_q   <= a_i[63] ^ b_i[63];
      c1_q     <= c_i;
      pp_q[0]  <= 64'(ua_q[31:0])  * 64'(ub_q[31:0]);
      pp_q[1]  <= 64'(ua_q[31:0])  * 64'(ub_q[63:32]);
      pp_q[2]  <= 64'(ua_q[63:32]) * 64'(ub_q[31:0]);
      pp_q[3]  <= 64'(ua_q[63:32]) * 64'(ub_q[63:32]);
      neg2_q   <= neg1_q;
      c2_q     <= c1_q;
      mag_q    <= mag_d;
      neg3_q   <= neg2_q;
      c3_q     <= c2_q;
      y_q      <= y_d;
    end
  end

  assign y_o = y_q;

endmodule

[rtl/swd_poly.sv]
// Horner polynomial in x over a slice of the coefficient table, one multiply-add unit per term after the highest.
module swd_poly #(
  parameter int unsigned START = 0,
  parameter int unsigned NUM   = 3
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  swd_pkg::q44_t x_i,
  output swd_pkg::q44_t y_o
);

  localparam int unsigned STEPS = NUM - 1;

  swd_pkg::q44_t acc [STEPS+1];
  swd_pkg::q44_t xd  [STEPS];

  assign acc[0] = swd_pkg::COEF[START+NUM-1];
  assign xd[0]  = x_i;

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    swd_fmac u_fmac (
      .clk_i (clk_i),
      .en_i  (en_i),
      .a_i   (acc[k]),
      .b_i   (xd[k]),
      .c_i   (swd_pkg::COEF[START+NUM-2-k]),
      .y_o   (acc[k+1])
    );
    if (k + 1 < STEPS) begin : g_xd
      swd_dly #(.W(64), .N(swd_pkg::FMAC_LAT)) u_dly (
        .clk_i (clk_i),
        .en_i  (en_i),
        .d_i   (xd[k]),
        .q_o   (xd[k+1])
      );
    end
  end

  assign y_o = acc[STEPS];

endmodule

[rtl/swd_sqrt.sv]
// Pipelined bit-by-bit integer square root, three result bits per stage.
module swd_sqrt (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic [swd_pkg::SQ_XW-1:0] x_i,
  output logic [swd_pkg::SQ_RW-1:0] root_o
);

  localparam int unsigned XW = swd_pkg::SQ_XW;
  localparam int unsigned RW = swd_pkg::SQ_RW;
  localparam int unsigned NS = swd_pkg::SQ_STAGES;
  localparam int unsigned SP = swd_pkg::SQ_SPS;

  logic [XW-1:0] y_q [NS];
  logic [RW-1:0] r_q [NS];
  logic [XW-1:0] y_d [NS];
  logic [RW-1:0] r_d [NS];

  // y holds x - r*r; a trial bit is kept when its increment fits.
  always_comb begin
    logic [XW:0]   inc;
    logic [XW-1:0] y;
    logic [RW-1:0] r;
    inc = '0;
    for (int g = 0; g < NS; g++) begin
      if (g == 0) begin
        y = x_i;
        r = '0;
      end else begin
        y = y_q[g-1];
        r = r_q[g-1];
      end
      for (int j = 0; j < SP; j++) begin
        inc = ((XW+1)'(r) << (RW - g*SP - j))
            | ((XW+1)'(1) << (2*(RW - 1 - g*SP - j)));
        if (inc <= {1'b0, y}) begin
          y = y - inc[XW-1:0];
          r = r | (RW'(1) << (RW - 1 - g*SP - j));
        end
      end
      y_d[g] = y;
      r_d[g] = r;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < NS; g++) begin
        y_q[g] <= y_d[g];
        r_q[g] <= r_d[g];
      end
    end
  end

  assign root_o = r_q[NS-1];

endmodule

[rtl/swd_div.sv]
// Pipelined restoring division giving floor(n * 2^44 / d), two quotient bits per stage.
module swd_div (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [63:0]                n_i,
  input  logic [63:0]                d_i,
  output logic [swd_pkg::DIV_QW-1:0] q_o
);

  localparam int unsigned QW = swd_pkg::DIV_QW;
  localparam int unsigned NS = swd_pkg::DIV_STAGES;
  localparam int unsigned SP = swd_pkg::DIV_SPS;

  logic [63:0]   r_q [NS];
  logic [63:0]   d_q [NS];
  logic [QW-1:0] q_q [NS];
  logic [63:0]   r_d [NS];
  logic [QW-1:0] q_d [NS];

  // The dividend is n followed by 44 zero bits; its top part seeds the remainder.
  always_comb begin
    logic [64:0]   r2;
    logic [63:0]   r, d;
    logic [QW-1:0] q;
    logic          nb;
    r2 = '0;
    for (int g = 0; g < NS; g++) begin
      if (g == 0) begin
        r = {2'b00, n_i[63:2]};
        d = d_i;
        q = '0;
      end else begin
        r = r_q[g-1];
        d = d_q[g-1];
        q = q_q[g-1];
      end
      for (int j = 0; j < SP; j++) begin
        nb = 1'b0;
        if (g == 0 && j == 0) begin
          nb = n_i[1];
        end else if (g == 0 && j == 1) begin
          nb = n_i[0];
        end
        r2 = {r, nb};
        if (r2 >= {1'b0, d}) begin
          r2 = r2 - {1'b0, d};
          q  = {q[QW-2:0], 1'b1};
        end else begin
          q  = {q[QW-2:0], 1'b0};
        end
        r = r2[63:0];
      end
      r_d[g] = r;
      q_d[g] = q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int g = 0; g < NS; g++) begin
        r_q[g] <= r_d[g];
        q_q[g] <= q_d[g];
        d_q[g] <= (g == 0) ? d_i : d_q[g-1];
      end
    end
  end

  assign q_o = q_q[NS-1];

endmodule
